[hdl/mxfp4_pkg.sv]
// mxfp4_pkg: shared binary32 constants, the nan scale code and the stage 1 request type
// used by mxfp4_lane and mx_fp4_dequantizer; no dependencies
package mxfp4_pkg;
	localparam logic [31:0] QNAN_BITS = 32'h7FC0_0000;
	localparam logic [31:0] INF_BITS  = 32'h7F80_0000;
	localparam logic [7:0]  SCALE_NAN = 8'hFF;

	typedef struct packed {
		logic [7:0] weight_byte;
		logic [7:0] scale_exp;
		logic       last;
		logic       low_first;
	} req_t;
endpackage

[hdl/mxfp4_lane.sv]
// mxfp4_lane: decodes one e2m1 code scaled by 2^(e-127) into binary32 bits
// depends on mxfp4_pkg
module mxfp4_lane
	import mxfp4_pkg::*;
(
	input  logic [3:0]  code,
	input  logic [7:0]  scale_exp,
	output logic [31:0] value
);
	logic       sign;
	logic [1:0] ex;
	logic       m;
	logic [9:0] biased;
	logic [2:0] halves;
	logic [4:0] shamt;
	logic [22:0] sub_frac;

	always_comb begin
		sign = code[3];
		ex = code[2:1];
		m = code[0];
		if (ex == 2'd0) begin
			halves = 3'd1;
			biased = {2'b00, scale_exp} - 10'd1;
		end else begin
			halves = 3'({1'b1, m}) << (ex - 2'd1);
			biased = {2'b00, scale_exp} + {8'd0, ex} - 10'd1;
		end
		// subnormal only arises for e <= 1, shift is e+21
		shamt = 5'(scale_exp[0]) + 5'd21;
		sub_frac = 23'(halves) << shamt;
		if (scale_exp == SCALE_NAN) begin
			value = QNAN_BITS;
		end else if (ex == 2'd0 && !m) begin
			value = {sign, 31'd0};
		end else if (!biased[9] && biased >= 10'd255) begin
			value = {sign, INF_BITS[30:0]};
		end else if (!biased[9] && biased != 10'd0) begin
			value = {sign, biased[7:0], (ex != 2'd0) & m, 22'd0};
		end else begin
			value = {sign, 8'd0, sub_frac};
		end
	end
endmodule

[hdl/mx_fp4_dequantizer.sv]
// mx_fp4_dequantizer: mxfp4 weight byte to two binary32 values
// pipeline: a request passes through the input register, then the result register
// throughput: one request per cycle, stalls only when both stages are full and out_stall is high
// reset: arst_n clears valid flags and sets low_first_q to 1
// depends on mxfp4_pkg and mxfp4_lane
module mx_fp4_dequantizer
	import mxfp4_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  weight_byte,
	input  logic [7:0]  scale_exp,
	input  logic        last_in,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] even_value,
	output logic [31:0] odd_value,
	output logic        last_out
);
	logic        low_first_q;
	req_t        req_s1;
	logic        vld_s1;
	logic        vld_s2;
	logic [31:0] even_s2, odd_s2;
	logic        last_s2;
	logic        adv_s2, adv_s1;
	logic [3:0]  even_code, odd_code;
	logic [31:0] even_d, odd_d;

	assign cfg_ready = 1'b1;
	assign adv_s2 = !vld_s2 || !out_stall;
	assign adv_s1 = !vld_s1 || adv_s2;
	assign in_stall = !adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_first_q <= 1'b1;
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (cfg_valid) low_first_q <= cfg_data;
			if (adv_s1) vld_s1 <= in_valid;
			if (adv_s2) vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && in_valid) begin
			req_s1 <= '{weight_byte: weight_byte, scale_exp: scale_exp,
				last: last_in, low_first: low_first_q};
		end
		if (adv_s2 && vld_s1) begin
			even_s2 <= even_d;
			odd_s2 <= odd_d;
			last_s2 <= req_s1.last;
		end
	end

	assign even_code = req_s1.low_first ? req_s1.weight_byte[3:0] : req_s1.weight_byte[7:4];
	assign odd_code  = req_s1.low_first ? req_s1.weight_byte[7:4] : req_s1.weight_byte[3:0];

	mxfp4_lane u_even (.code(even_code), .scale_exp(req_s1.scale_exp), .value(even_d));
	mxfp4_lane u_odd  (.code(odd_code),  .scale_exp(req_s1.scale_exp), .value(odd_d));

	assign out_valid  = vld_s2;
	assign even_value = even_s2;
	assign odd_value  = odd_s2;
	assign last_out   = last_s2;

`ifndef SYNTH
	a_nan_both: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s2 && vld_s1 && req_s1.scale_exp == SCALE_NAN) |=>
		(even_s2 == QNAN_BITS && odd_s2 == QNAN_BITS))
		else $error("nan scale not in both lanes");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s2 && out_stall) |=> (vld_s2 && $stable(even_s2) && $stable(odd_s2)))
		else $error("result changed under stall");
	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s1 && !adv_s2) |=> vld_s1)
		else $error("stage 1 request lost");
`endif
endmodule
